>>> sv/solar_to_lunar_date_converter_top_defines.svh
// Assertion helpers used by the converter top.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef SOLAR_TO_LUNAR_DATE_CONVERTER_TOP_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_CONVERTER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define STLC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define STLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/stlc_pkg.sv
package stlc_pkg;

    localparam int TABLE_YEARS = 163;
    localparam int ROW_W       = $clog2(TABLE_YEARS + 1);
    localparam int ACC_W       = 16;
    localparam int CODE_DIGITS = 13;

    localparam logic [11:0] FIRST_YEAR = 12'd1881;
    localparam logic [11:0] LAST_YEAR  = 12'(1880 + TABLE_YEARS);
    // Lunar 1881-01-01 falls on solar 1881-01-30
    localparam logic [ACC_W-1:0] EPOCH_DAYS = 16'd29;

    // Residues of the first table year, used to seed the leap-year counters
    localparam logic [1:0] FIRST_MOD4   = 2'd1;
    localparam logic [6:0] FIRST_MOD100 = 7'd81;
    localparam logic [8:0] FIRST_MOD400 = 9'd281;

    // One lunar year per entry, one hex nibble per month digit, first month in the top nibble
    typedef logic [4*CODE_DIGITS-1:0] year_code_t;
    typedef logic [8:0] year_len_t;
    typedef year_len_t year_len_arr_t [TABLE_YEARS];

    localparam year_code_t YEAR_CODES [TABLE_YEARS] = '{
        52'h1212122322121, 52'h1212121221220, 52'h1121121222120, 52'h2112132122122,
        52'h2112112121220, 52'h2121211212120, 52'h2212321121212, 52'h2122121121210,
        52'h2122121212120, 52'h1232122121212, 52'h1212121221220, 52'h1121123221222,
        52'h1121121212220, 52'h1212112121220, 52'h2121231212121, 52'h2221211212120,
        52'h1221212121210, 52'h2123221212121, 52'h2121212212120, 52'h1211212232212,
        52'h1211212122210, 52'h2121121212220, 52'h1212132112212, 52'h2212112112210,
        52'h2212211212120, 52'h1221412121212, 52'h1212122121210, 52'h2112212122120,
        52'h1231212122212, 52'h1211212122210, 52'h2121123122122, 52'h2121121122120,
        52'h2212112112120, 52'h2212231212112, 52'h2122121212120, 52'h1212122121210,
        52'h2132122122121, 52'h2112121222120, 52'h1211212322122, 52'h1211211221220,
        52'h2121121121220, 52'h2122132112122, 52'h1221212121120, 52'h2121221212110,
        52'h2122321221212, 52'h1121212212210, 52'h2112121221220, 52'h1231211221222,
        52'h1211211212220, 52'h1221123121221, 52'h2221121121210, 52'h2221212112120,
        52'h1221241212112, 52'h1212212212120, 52'h1121212212210, 52'h2114121212221,
        52'h2112112122210, 52'h2211211412212, 52'h2211211212120, 52'h2212121121210,
        52'h2212214112121, 52'h2122122121120, 52'h1212122122120, 52'h1121412122122,
        52'h1121121222120, 52'h2112112122120, 52'h2231211212122, 52'h2121211212120,
        52'h2212121321212, 52'h2122121121210, 52'h2122121212120, 52'h1212142121212,
        52'h1211221221220, 52'h1121121221220, 52'h2114112121222, 52'h1212112121220,
        52'h2121211232122, 52'h1221211212120, 52'h1221212121210, 52'h2121223212121,
        52'h2121212212120, 52'h1211212212210, 52'h2121321212221, 52'h2121121212220,
        52'h1212112112210, 52'h2223211211221, 52'h2212211212120, 52'h1221212321212,
        52'h1212122121210, 52'h2112212122120, 52'h1211232122212, 52'h1211212122210,
        52'h2121121122210, 52'h2212312112212, 52'h2212112112120, 52'h2212121232112,
        52'h2122121212110, 52'h2212122121210, 52'h2112124122121, 52'h2112121221220,
        52'h1211211221220, 52'h2121321122122, 52'h2121121121220, 52'h2122112112322,
        52'h1221212112120, 52'h1221221212110, 52'h2122123221212, 52'h1121212212210,
        52'h2112121221220, 52'h1211231212222, 52'h1211211212220, 52'h1221121121220,
        52'h1223212112121, 52'h2221212112120, 52'h1221221232112, 52'h1212212122120,
        52'h1121212212210, 52'h2112132212221, 52'h2112112122210, 52'h2211211212210,
        52'h2221321121212, 52'h2212121121210, 52'h2212212112120, 52'h1232212122112,
        52'h1212122122120, 52'h1121212322122, 52'h1121121222120, 52'h2112112122120,
        52'h2211231212122, 52'h2121211212120, 52'h2122121121210, 52'h2124212112121,
        52'h2122121212120, 52'h1212121223212, 52'h1211212221220, 52'h1121121221220,
        52'h2112132121222, 52'h1212112121220, 52'h2121211212120, 52'h2122321121212,
        52'h1221212121210, 52'h2121221212120, 52'h1232121221212, 52'h1211212212210,
        52'h2121123212221, 52'h2121121212220, 52'h1212112112220, 52'h1221231211221,
        52'h2212211211220, 52'h1212212121210, 52'h2123212212121, 52'h2112122122120,
        52'h1211212322212, 52'h1211212122210, 52'h2121121122120, 52'h2212114112122,
        52'h2212112112120, 52'h2212121211210, 52'h2212232121211, 52'h2122122121210,
        52'h2112122122120, 52'h1231212122212, 52'h1211211221220
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SOLAR,
        ST_DOY,
        ST_EPOCH,
        ST_LYEAR,
        ST_LMONTH
    } stlc_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stlc_status_t;

    typedef struct packed {
        logic        valid_res;
        logic        leap_month;
        logic [4:0]  lunar_day;
        logic [3:0]  lunar_month;
        logic [11:0] lunar_year;
    } stlc_result_t;

    function automatic logic [4:0] lunar_month_len(input logic [3:0] dig);
        logic [4:0] len;
        case (dig)
            4'd1, 4'd3: len = 5'd29;
            4'd2, 4'd4: len = 5'd30;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [4:0] solar_month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                   len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days of a common year that come before the first of month m
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] days;
        case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic year_len_arr_t calc_year_lens();
        year_len_arr_t lens;
        year_len_t     sum;
        for (int r = 0; r < TABLE_YEARS; r++)
        begin
            sum = '0;
            for (int p = 0; p < CODE_DIGITS; p++)
            begin
                sum = sum + year_len_t'(lunar_month_len(YEAR_CODES[r][4*(CODE_DIGITS-1-p) +: 4]));
            end
            lens[r] = sum;
        end
        return lens;
    endfunction

    localparam year_len_arr_t YEAR_LENS = calc_year_lens();

endpackage

>>> sv/stlc_core.sv
module stlc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [11:0]          solar_year,
    input  logic [3:0]           solar_month,
    input  logic [4:0]           solar_day,
    output stlc_pkg::stlc_status_t stat,
    output stlc_pkg::stlc_result_t result
);
    import stlc_pkg::*;

    stlc_state_t state_reg, state_next;

    logic [11:0]      year_reg, year_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       day_reg, day_next;
    logic [11:0]      cur_year_reg, cur_year_next;
    logic [1:0]       mod4_reg, mod4_next;
    logic [6:0]       mod100_reg, mod100_next;
    logic [8:0]       mod400_reg, mod400_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [3:0]       digit_reg, digit_next;
    logic [3:0]       num_reg, num_next;
    logic             leap_reg, leap_next;

    logic             is_leap;
    logic             in_bad;
    logic [4:0]       mlen;
    logic [ACC_W-1:0] doy;
    logic [ROW_W-1:0] row_idx;
    logic             row_end;
    year_code_t       cur_code;
    year_len_t        cur_ylen;
    logic [3:0]       dig;
    logic [3:0]       last_digit;
    logic             small_dig;
    logic [5:0]       lim;
    logic             in_month;
    logic [3:0]       month_num;
    logic [ACC_W-1:0] acc_sub;
    logic [ACC_W-1:0] operand;

    assign is_leap = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (mod4_reg == 2'd0));
    assign in_bad  = (year_reg < FIRST_YEAR) || (year_reg > LAST_YEAR) ||
                     (month_reg == 4'd0) || (month_reg > 4'd12) || (day_reg == 5'd0);
    assign mlen    = solar_month_len(month_reg) +
                     5'((month_reg == 4'd2) && is_leap);
    assign doy     = ACC_W'(days_before_month(month_reg)) +
                     ACC_W'((month_reg > 4'd2) && is_leap) + ACC_W'(day_reg);

    assign row_end    = (row_reg == ROW_W'(TABLE_YEARS));
    assign row_idx    = row_end ? '0 : row_reg;
    assign cur_code   = YEAR_CODES[row_idx];
    assign cur_ylen   = YEAR_LENS[row_idx];
    // digit 0 is the top nibble
    assign dig        = cur_code[(4*(CODE_DIGITS-1) - 4*int'(digit_reg)) +: 4];
    assign last_digit = (cur_code[3:0] == 4'd0) ? 4'd11 : 4'd12;
    assign small_dig  = (dig <= 4'd2);
    assign lim        = small_dig ? 6'(dig + 4'd0) + 6'd28 : 6'(dig) + 6'd26;
    assign in_month   = (acc_reg <= ACC_W'(lim));
    assign month_num  = small_dig ? num_reg + 4'd1 : num_reg;

    // Shared subtractor: take a year length, a month length or the epoch offset
    always_comb
    begin
        case (state_reg)
            ST_LYEAR:  operand = ACC_W'(cur_ylen);
            ST_LMONTH: operand = ACC_W'(lim);
            default:   operand = EPOCH_DAYS;
        endcase
    end
    assign acc_sub = acc_reg - operand;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = in_bad ? ST_IDLE : ST_SOLAR;
            end
            ST_SOLAR:
            begin
                if (cur_year_reg == year_reg)
                    state_next = ST_DOY;
            end
            ST_DOY:
            begin
                state_next = (day_reg > mlen) ? ST_IDLE : ST_EPOCH;
            end
            ST_EPOCH:
            begin
                state_next = (acc_reg <= EPOCH_DAYS) ? ST_IDLE : ST_LYEAR;
            end
            ST_LYEAR:
            begin
                if (row_end)
                    state_next = ST_IDLE;
                else if (acc_reg <= ACC_W'(cur_ylen))
                    state_next = ST_LMONTH;
            end
            ST_LMONTH:
            begin
                if (in_month || (digit_reg == last_digit))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        cur_year_next = cur_year_reg;
        mod4_next     = mod4_reg;
        mod100_next   = mod100_reg;
        mod400_next   = mod400_reg;
        acc_next      = acc_reg;
        row_next      = row_reg;
        digit_next    = digit_reg;
        num_next      = num_reg;
        leap_next     = leap_reg;
        stat.idle     = (state_reg == ST_IDLE);
        stat.done     = 1'b0;
        result        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    year_next     = solar_year;
                    month_next    = solar_month;
                    day_next      = solar_day;
                    cur_year_next = FIRST_YEAR;
                    mod4_next     = FIRST_MOD4;
                    mod100_next   = FIRST_MOD100;
                    mod400_next   = FIRST_MOD400;
                    acc_next      = '0;
                    row_next      = '0;
                    digit_next    = '0;
                    num_next      = '0;
                    leap_next     = 1'b0;
                end
            end
            ST_CHECK:
            begin
                stat.done = in_bad;
            end
            ST_SOLAR:
            begin
                // advance one Gregorian year
                if (cur_year_reg != year_reg)
                begin
                    acc_next      = acc_reg + (is_leap ? 16'd366 : 16'd365);
                    cur_year_next = cur_year_reg + 12'd1;
                    mod4_next     = mod4_reg + 2'd1;
                    mod100_next   = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next   = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            ST_DOY:
            begin
                acc_next  = acc_reg + doy;
                stat.done = (day_reg > mlen);
            end
            ST_EPOCH:
            begin
                acc_next  = acc_sub;
                stat.done = (acc_reg <= EPOCH_DAYS);
            end
            ST_LYEAR:
            begin
                stat.done = row_end;
                if (!row_end && (acc_reg > ACC_W'(cur_ylen)))
                begin
                    acc_next = acc_sub;
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_LMONTH:
            begin
                num_next   = month_num;
                leap_next  = !small_dig;
                digit_next = digit_reg + 4'd1;
                if (!in_month)
                    acc_next = acc_sub;
                if (in_month || (digit_reg == last_digit))
                begin
                    stat.done          = 1'b1;
                    result.valid_res   = 1'b1;
                    result.leap_month  = !small_dig;
                    result.lunar_day   = in_month ? acc_reg[4:0] : acc_sub[4:0];
                    result.lunar_month = month_num;
                    result.lunar_year  = FIRST_YEAR + 12'(row_reg);
                end
            end
            default:
            begin
                stat.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        year_reg     <= year_next;
        month_reg    <= month_next;
        day_reg      <= day_next;
        cur_year_reg <= cur_year_next;
        mod4_reg     <= mod4_next;
        mod100_reg   <= mod100_next;
        mod400_reg   <= mod400_next;
        acc_reg      <= acc_next;
        row_reg      <= row_next;
        digit_reg    <= digit_next;
        num_reg      <= num_next;
        leap_reg     <= leap_next;
    end

endmodule

>>> sv/solar_to_lunar_date_converter_top.sv
// The core checks the date, walks solar years from 1881, adds the day of year, takes off the epoch
// offset and walks lunar years and months to m_axis_tvalid; a bad year, month or zero day is
// rejected at the check, a day past the month end after the solar walk, one before the epoch at
// the epoch step. Throughput: one transaction at a time; an adder walks one solar year and the
// shared subtractor one lunar row or month per cycle; s_axis_tready returns the cycle after output.
// Reset: rst_n asynchronously clears the sequencer and the output valid; no clearing pass.
`include "solar_to_lunar_date_converter_top_defines.svh"

module solar_to_lunar_date_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // solar_year[11:0], solar_month[15:12], solar_day[20:16], zero fill [23:21]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lunar_year[11:0], lunar_month[15:12], lunar_day[20:16], leap_month[21],
    // valid_res[22], zero fill [23]
    output logic [23:0] m_axis_tdata
);
    import stlc_pkg::*;

    stlc_status_t core_stat;
    stlc_result_t core_res;
    stlc_result_t out_res_reg, out_res_next;
    logic         out_valid_reg, out_valid_next;
    logic         in_xfer;
    logic         out_xfer;

    // Take a new transaction only when the sequencer is idle and the result slot is empty
    assign s_axis_tready = core_stat.idle && !out_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    stlc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_xfer),
        .solar_year  (s_axis_tdata[11:0]),
        .solar_month (s_axis_tdata[15:12]),
        .solar_day   (s_axis_tdata[20:16]),
        .stat        (core_stat),
        .result      (core_res)
    );

    // Hold the finished result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (core_stat.done)
        begin
            out_valid_next = 1'b1;
            out_res_next   = core_res;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.valid_res, out_res_reg.leap_month,
                            out_res_reg.lunar_day, out_res_reg.lunar_month,
                            out_res_reg.lunar_year};

    // Never accept input while a result is pending
    `STLC_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input ready while result pending")
    // An accepted input occupies the sequencer for at least the next cycle
    `STLC_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_axis_tready, "ready right after accept")
    // The core finishes only while the result slot is free
    `STLC_ASSERT(a_done_slot_free, !(core_stat.done && out_valid_reg), "result overwritten")
    // A rejected date carries all-zero fields
    `STLC_ASSERT(a_invalid_zero, !m_axis_tvalid || m_axis_tdata[22] || (m_axis_tdata[21:0] == 22'd0),
                 "invalid result with nonzero fields")
    // A converted date has a sane lunar day and month
    `STLC_ASSERT(a_valid_range, !m_axis_tvalid || !m_axis_tdata[22] ||
                 ((m_axis_tdata[20:16] != 5'd0) && (m_axis_tdata[20:16] <= 5'd30) &&
                  (m_axis_tdata[15:12] != 4'd0) && (m_axis_tdata[15:12] <= 4'd12)),
                 "lunar day or month out of range")

endmodule
